// ----- hdl/assert_macros.svh -----
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CDF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Expression must never be true outside reset.
`define CDF_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

// ----- hdl/cdf_pkg.sv -----
package cdf_pkg;

  localparam logic [7:0]  HDR0          = 8'h53;
  localparam logic [7:0]  HDR1          = 8'h47;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam int          FRAME_OVERHEAD = 7;
  localparam int          MAX_RESULTS   = 38;
  localparam int          RES_CNT_W     = 6;
  localparam logic [0:0]  REG_BOARD_ADDR = 1'b0;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_FRAME   = 2'd1,
    KIND_CRC_BAD = 2'd2,
    KIND_READ    = 2'd3
  } cdf_kind_e;

  typedef enum logic [2:0] {
    OFF_HOLD,
    OFF_ZERO,
    OFF_ONE,
    OFF_TWO,
    OFF_THREE,
    OFF_FOUR,
    OFF_FIVE,
    OFF_INC
  } cdf_off_e;

  typedef struct packed {
    logic     push;
    logic     load_rd;
    cdf_off_e off_sel;
    logic     drop1;
    logic     drop_frame;
    logic     len_load;
    logic     cmd_load;
    logic     crc_init;
    logic     crc_step;
    logic     lo_load;
    logic     pl_write;
    logic     acc_load;
    logic     pend_load;
    logic     pend_bad;
    logic     out_load_pend;
    logic     out_load_none;
    logic     out_load_read;
    logic     out_last;
  } cdf_cmd_t;

  typedef struct packed {
    logic empty;
    logic ge2;
    logic ge3;
    logic ge5;
    logic hdr0_ok;
    logic hdr1_ok;
    logic addr_ok;
    logic len_fits;
    logic len_zero;
    logic walk_last;
    logic crc_ok;
    logic pend_valid;
    logic out_free;
  } cdf_status_t;

  // One byte of the reflected CRC-16, LSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- hdl/cdf_in_if.sv -----
interface cdf_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;
  logic [7:0] read_index;

  modport source (output valid, action, rx_byte, read_index, input ready);
  modport sink (input valid, action, rx_byte, read_index, output ready);
endinterface

// ----- hdl/cdf_out_if.sv -----
interface cdf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] frame_cmd;
  logic [7:0] body_len;
  logic [7:0] read_data;
  logic       last_result;

  modport source (output valid, result_kind, frame_cmd, body_len, read_data, last_result,
                  input ready);
  modport sink (input valid, result_kind, frame_cmd, body_len, read_data, last_result,
                output ready);
endinterface

// ----- hdl/cdf_ctrl.sv -----
module cdf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_action_i,
  output logic                 in_ready_o,
  input  cdf_pkg::cdf_status_t status_i,
  output cdf_pkg::cdf_cmd_t    cmd_o
);
  import cdf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RDWAIT, ST_CHK0, ST_W0, ST_W1, ST_W2, ST_W4, ST_W3,
    ST_CRC, ST_RLO, ST_RHI, ST_COPY, ST_EMIT_OK, ST_EMIT_BAD, ST_FINISH
  } state_e;

  state_e               state_q, state_d;
  logic [RES_CNT_W-1:0] n_q, n_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_action_i) begin
            cmd_o.load_rd = 1'b1;
            state_d       = ST_RDWAIT;
          end else begin
            cmd_o.push = 1'b1;
            n_d        = '0;
            state_d    = ST_CHK0;
          end
        end
      end
      ST_RDWAIT: begin
        if (status_i.out_free) begin
          cmd_o.out_load_read = 1'b1;
          state_d             = ST_IDLE;
        end
      end
      ST_CHK0: begin
        cmd_o.off_sel = OFF_ZERO;
        if (status_i.empty || n_q == RES_CNT_W'(MAX_RESULTS)) state_d = ST_FINISH;
        else state_d = ST_W0;
      end
      ST_W0: begin
        if (!status_i.hdr0_ok) begin
          cmd_o.drop1 = 1'b1;
          state_d     = ST_CHK0;
        end else if (!status_i.ge2) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.off_sel = OFF_ONE;
          state_d       = ST_W1;
        end
      end
      ST_W1: begin
        if (!status_i.hdr1_ok) begin
          cmd_o.drop1 = 1'b1;
          state_d     = ST_CHK0;
        end else if (!status_i.ge3) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.off_sel = OFF_TWO;
          state_d       = ST_W2;
        end
      end
      ST_W2: begin
        if (!status_i.addr_ok) begin
          cmd_o.drop1 = 1'b1;
          state_d     = ST_CHK0;
        end else if (!status_i.ge5) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.off_sel = OFF_FOUR;
          state_d       = ST_W4;
        end
      end
      ST_W4: begin
        cmd_o.len_load = 1'b1;
        if (!status_i.len_fits) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.off_sel = OFF_THREE;
          state_d       = ST_W3;
        end
      end
      ST_W3: begin
        cmd_o.cmd_load = 1'b1;
        cmd_o.crc_init = 1'b1;
        cmd_o.off_sel  = OFF_ZERO;
        state_d        = ST_CRC;
      end
      ST_CRC: begin
        cmd_o.crc_step = 1'b1;
        cmd_o.off_sel  = OFF_INC;
        if (status_i.walk_last) state_d = ST_RLO;
      end
      ST_RLO: begin
        cmd_o.lo_load = 1'b1;
        cmd_o.off_sel = OFF_INC;
        state_d       = ST_RHI;
      end
      ST_RHI: begin
        if (!status_i.crc_ok) begin
          state_d = ST_EMIT_BAD;
        end else if (status_i.len_zero) begin
          state_d = ST_EMIT_OK;
        end else begin
          cmd_o.off_sel = OFF_FIVE;
          state_d       = ST_COPY;
        end
      end
      ST_COPY: begin
        cmd_o.pl_write = 1'b1;
        cmd_o.off_sel  = OFF_INC;
        if (status_i.walk_last) state_d = ST_EMIT_OK;
      end
      ST_EMIT_OK, ST_EMIT_BAD: begin
        if (!status_i.pend_valid || status_i.out_free) begin
          cmd_o.out_load_pend = status_i.pend_valid;
          cmd_o.pend_load     = 1'b1;
          cmd_o.pend_bad      = (state_q == ST_EMIT_BAD);
          cmd_o.acc_load      = (state_q == ST_EMIT_OK);
          cmd_o.drop_frame    = (state_q == ST_EMIT_OK);
          cmd_o.drop1         = (state_q == ST_EMIT_BAD);
          n_d                 = n_q + 1'b1;
          state_d             = ST_CHK0;
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.out_load_pend = status_i.pend_valid;
          cmd_o.out_load_none = !status_i.pend_valid;
          cmd_o.out_last      = 1'b1;
          state_d             = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
    end
  end

endmodule

// ----- hdl/cdf_datapath.sv -----
module cdf_datapath #(
  parameter int FRAME_STORE_DEPTH = 512,
  parameter int PAYLOAD_DEPTH     = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           board_addr_i,
  input  logic [7:0]           rx_byte_i,
  input  logic [7:0]           read_index_i,
  input  cdf_pkg::cdf_cmd_t    cmd_i,
  output cdf_pkg::cdf_status_t status_o,
  cdf_out_if.source            out_o
);
  import cdf_pkg::*;

  localparam int IDX_W  = $clog2(FRAME_STORE_DEPTH);
  localparam int CNT_W  = $clog2(FRAME_STORE_DEPTH + 1);
  localparam int PIDX_W = $clog2(PAYLOAD_DEPTH);
  localparam logic [IDX_W:0] DEPTH_X = (IDX_W + 1)'(FRAME_STORE_DEPTH);

  logic [7:0] store_mem [FRAME_STORE_DEPTH];
  logic [7:0] pl_mem [PAYLOAD_DEPTH];

  logic [IDX_W-1:0] head_q, head_d, off_q, off_d, rd_addr, wr_addr;
  logic [CNT_W-1:0] count_q, count_d;
  logic [7:0]       rd_q, len_q, cmd_q, lo_q, acc_len_q, pl_rd_q;
  logic [15:0]      crc_q;
  logic             rd_ok_q;
  logic             pend_valid_q;
  cdf_kind_e        pend_kind_q;
  logic [7:0]       pend_cmd_q, pend_len_q;
  logic             out_valid_q, out_last_q;
  cdf_kind_e        out_kind_q;
  logic [7:0]       out_cmd_q, out_len_q, out_data_q;
  logic [IDX_W:0]   frame_need;
  logic [IDX_W-1:0] pl_off;
  logic             full;

  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W:0] s);
    return (s >= DEPTH_X) ? IDX_W'(s - DEPTH_X) : IDX_W'(s);
  endfunction

  assign full       = (count_q == CNT_W'(FRAME_STORE_DEPTH));
  assign frame_need = (IDX_W + 1)'(FRAME_OVERHEAD) + (IDX_W + 1)'(len_q);
  assign pl_off     = off_q - IDX_W'(5);

  always_comb begin
    case (cmd_i.off_sel)
      OFF_ZERO:  off_d = '0;
      OFF_ONE:   off_d = IDX_W'(1);
      OFF_TWO:   off_d = IDX_W'(2);
      OFF_THREE: off_d = IDX_W'(3);
      OFF_FOUR:  off_d = IDX_W'(4);
      OFF_FIVE:  off_d = IDX_W'(5);
      OFF_INC:   off_d = off_q + 1'b1;
      default:   off_d = off_q;
    endcase
  end

  assign rd_addr = wrap_add({1'b0, head_q} + {1'b0, off_d});
  assign wr_addr = full ? head_q : wrap_add({1'b0, head_q} + (IDX_W + 1)'(count_q));

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (cmd_i.push) begin
      if (full) head_d = wrap_add({1'b0, head_q} + 1'b1);
      else count_d = count_q + 1'b1;
    end else if (cmd_i.drop_frame) begin
      head_d  = wrap_add({1'b0, head_q} + frame_need);
      count_d = count_q - CNT_W'(frame_need);
    end else if (cmd_i.drop1) begin
      head_d  = wrap_add({1'b0, head_q} + 1'b1);
      count_d = count_q - 1'b1;
    end
  end

  // Frame store: one write, one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) store_mem[wr_addr] <= rx_byte_i;
    rd_q <= store_mem[rd_addr];
  end

  // Payload store.
  always_ff @(posedge clk_i) begin
    if (cmd_i.pl_write && ({1'b0, pl_off} < (IDX_W + 1)'(PAYLOAD_DEPTH))) begin
      pl_mem[pl_off[PIDX_W-1:0]] <= rd_q;
    end
    if (cmd_i.load_rd) pl_rd_q <= pl_mem[read_index_i[PIDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.len_load) len_q <= rd_q;
    if (cmd_i.cmd_load) cmd_q <= rd_q;
    if (cmd_i.lo_load) lo_q <= rd_q;
    if (cmd_i.crc_init) crc_q <= CRC_INIT;
    else if (cmd_i.crc_step) crc_q <= crc16_byte(crc_q, rd_q);
    if (cmd_i.load_rd) begin
      rd_ok_q <= (read_index_i < acc_len_q) && ({1'b0, read_index_i} < 9'(PAYLOAD_DEPTH));
    end
    if (cmd_i.pend_load) begin
      pend_kind_q <= cmd_i.pend_bad ? KIND_CRC_BAD : KIND_FRAME;
      pend_cmd_q  <= cmd_i.pend_bad ? 8'h00 : cmd_q;
      pend_len_q  <= cmd_i.pend_bad ? 8'h00 : len_q;
    end
    if (cmd_i.out_load_pend) begin
      out_kind_q <= pend_kind_q;
      out_cmd_q  <= pend_cmd_q;
      out_len_q  <= pend_len_q;
      out_data_q <= 8'h00;
      out_last_q <= cmd_i.out_last;
    end else if (cmd_i.out_load_none || cmd_i.out_load_read) begin
      out_kind_q <= cmd_i.out_load_read ? KIND_READ : KIND_NONE;
      out_cmd_q  <= 8'h00;
      out_len_q  <= 8'h00;
      out_data_q <= (cmd_i.out_load_read && rd_ok_q) ? pl_rd_q : 8'h00;
      out_last_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      count_q      <= '0;
      off_q        <= '0;
      acc_len_q    <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      off_q   <= off_d;
      if (cmd_i.acc_load) acc_len_q <= len_q;
      if (cmd_i.pend_load) pend_valid_q <= 1'b1;
      else if (cmd_i.out_load_pend) pend_valid_q <= 1'b0;
      if (cmd_i.out_load_pend || cmd_i.out_load_none || cmd_i.out_load_read) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.empty      = (count_q == '0);
  assign status_o.ge2        = (count_q >= CNT_W'(2));
  assign status_o.ge3        = (count_q >= CNT_W'(3));
  assign status_o.ge5        = (count_q >= CNT_W'(5));
  assign status_o.hdr0_ok    = (rd_q == HDR0);
  assign status_o.hdr1_ok    = (rd_q == HDR1);
  assign status_o.addr_ok    = (rd_q == board_addr_i);
  assign status_o.len_fits   = (count_q >= CNT_W'(FRAME_OVERHEAD) + CNT_W'(rd_q));
  assign status_o.len_zero   = (len_q == 8'h00);
  assign status_o.walk_last  = (off_q == IDX_W'(4) + IDX_W'(len_q));
  assign status_o.crc_ok     = ({rd_q, lo_q} == crc_q);
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.out_free   = !out_valid_q || out_o.ready;

  assign out_o.valid       = out_valid_q;
  assign out_o.result_kind = out_kind_q;
  assign out_o.frame_cmd   = out_cmd_q;
  assign out_o.body_len    = out_len_q;
  assign out_o.read_data   = out_data_q;
  assign out_o.last_result = out_last_q;

endmodule

// ----- hdl/crc16_frame_deframer_unit.sv -----
// Channel  Dir  Carries                                           Transfer when
// in_i     in   action, rx_byte, read_index                       valid && ready
// out_o    out  result_kind, frame_cmd, body_len, read_data,      valid && ready
//               last_result
// apb      in   board_addr at byte address 0                      psel && penable && pwrite
//
// A read passes through a wait state and loads the output register once it is free.
// A push then checks each candidate's header bytes and length; a dropped byte sends
// the scan back to the first header byte. A candidate that fits is walked once for
// its CRC and, when it passes with a body, once more for the payload copy, as the CRC
// walk and payload copy share the single read port of the frame store.
// Reset clears all control state at once; no clearing pass is run.
// A stalled output holds the scan at its next result; input is taken only when idle.
module crc16_frame_deframer_unit #(
  parameter int FRAME_STORE_DEPTH = 512,
  parameter int PAYLOAD_DEPTH     = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  cdf_in_if.sink      in_i,
  cdf_out_if.source   out_o
);
  import cdf_pkg::*;
  `include "assert_macros.svh"

  logic [7:0]  board_addr_q;
  cdf_cmd_t    cmd;
  cdf_status_t status;
  logic        in_idle;
  logic        out_mid;

  // Config port: one register, always ready, written in the access phase.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BOARD_ADDR) ? {24'h0, board_addr_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_addr_q <= 8'h01;
    end else if (psel && penable && pwrite && (paddr[2] == REG_BOARD_ADDR)) begin
      board_addr_q <= pwdata[7:0];
    end
  end

  // Sequencer: decides header checks, CRC walk, copy and result order.
  cdf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_action_i(in_i.action),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Stores, CRC, pending result and output register.
  cdf_datapath #(
    .FRAME_STORE_DEPTH(FRAME_STORE_DEPTH),
    .PAYLOAD_DEPTH    (PAYLOAD_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .board_addr_i(board_addr_q),
    .rx_byte_i   (in_i.rx_byte),
    .read_index_i(in_i.read_index),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_o       (out_o)
  );

  assign in_idle = in_i.ready;
  assign out_mid = out_o.valid && !out_o.last_result;

  // A result held back for ordering must be flushed before the next transfer in.
  `CDF_ASSERT_NEVER(a_pend_when_idle, clk_i, rst_ni, in_idle && status.pend_valid, "pend at idle")
  // Once idle, any result still shown must be the final one of its item.
  `CDF_ASSERT_NEVER(a_idle_last, clk_i, rst_ni, in_idle && out_mid, "non-final result at idle")
  // An accepted item always leaves the unit busy in the cycle after it is taken.
  `CDF_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_i.valid && in_idle) |=> !in_idle, "busy")

endmodule

// ----- tb/tb_crc16_frame_deframer_unit.sv -----
`timescale 1ns / 100ps

module tb_crc16_frame_deframer_unit;
  import cdf_pkg::*;

  localparam int STORE_DEPTH  = 512;
  localparam int PL_DEPTH     = 256;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int DRAIN_CYCLES = 600;

  typedef struct {
    cdf_kind_e  kind;
    logic [7:0] cmd;
    logic [7:0] len;
    logic [7:0] data;
    logic       last;
  } deframe_res_t;

  // Scoreboard: mirrors the frame hunt and holds the results still owed by the block.
  class deframe_scoreboard;
    logic [7:0]   board_addr;
    logic [7:0]   rx_store[$];
    logic [7:0]   payload[PL_DEPTH];
    logic [7:0]   acc_len;
    deframe_res_t owed[$];
    int           errors;

    function new();
      board_addr = 8'd1;
      acc_len    = 8'd0;
      errors     = 0;
    endfunction

    function logic [15:0] crc_of_store(int count);
      logic [15:0] crc;
      crc = 16'hFFFF;
      for (int i = 0; i < count; i++) begin
        crc ^= {8'h00, rx_store[i]};
        for (int b = 0; b < 8; b++) crc = crc[0] ? ((crc >> 1) ^ 16'hA001) : (crc >> 1);
      end
      return crc;
    endfunction

    function void owe(cdf_kind_e k, logic [7:0] c, logic [7:0] l, logic [7:0] d);
      deframe_res_t r;
      r.kind = k; r.cmd = c; r.len = l; r.data = d; r.last = 1'b0;
      owed.push_back(r);
    endfunction

    // Predict the results of one accepted input transfer.
    function void note_input(logic act, logic [7:0] rx, logic [7:0] idx);
      int          n;
      int          need;
      logic [7:0]  flen;
      logic [15:0] crc, got;
      if (act) begin
        owe(KIND_READ, 8'd0, 8'd0, (idx < acc_len) ? payload[idx] : 8'd0);
        owed[$].last = 1'b1;
        return;
      end
      if (rx_store.size() >= STORE_DEPTH) void'(rx_store.pop_front());
      rx_store.push_back(rx);
      n = 0;
      while (n < MAX_RESULTS && rx_store.size() > 0) begin
        if (rx_store[0] != HDR0) begin void'(rx_store.pop_front()); continue; end
        if (rx_store.size() < 2) break;
        if (rx_store[1] != HDR1) begin void'(rx_store.pop_front()); continue; end
        if (rx_store.size() < 3) break;
        if (rx_store[2] != board_addr) begin void'(rx_store.pop_front()); continue; end
        if (rx_store.size() < 5) break;
        flen = rx_store[4];
        need = FRAME_OVERHEAD + flen;
        if (rx_store.size() < need) break;
        crc = crc_of_store(5 + flen);
        got = {rx_store[6 + flen], rx_store[5 + flen]};
        if (got == crc) begin
          for (int i = 0; i < flen; i++) payload[i] = rx_store[5 + i];
          acc_len = flen;
          owe(KIND_FRAME, rx_store[3], flen, 8'd0);
          repeat (need) void'(rx_store.pop_front());
        end else begin
          owe(KIND_CRC_BAD, 8'd0, 8'd0, 8'd0);
          void'(rx_store.pop_front());
        end
        n++;
      end
      if (n == 0) owe(KIND_NONE, 8'd0, 8'd0, 8'd0);
      owed[$].last = 1'b1;
    endfunction

    // Compare one result transfer against the oldest owed result.
    function void check_result(logic [1:0] k, logic [7:0] c, logic [7:0] l,
                               logic [7:0] d, logic lst);
      deframe_res_t e;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result kind=%0d cmd=%h len=%0d data=%h last=%b",
                 $time, k, c, l, d, lst);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (k !== e.kind || c !== e.cmd || l !== e.len || d !== e.data || lst !== e.last) begin
        $display("%0t: mismatch exp kind=%0d cmd=%h len=%0d data=%h last=%b", $time,
                 e.kind, e.cmd, e.len, e.data, e.last);
        $display("%0t:          got kind=%0d cmd=%h len=%0d data=%h last=%b", $time,
                 k, c, l, d, lst);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        hold_req = 1'b0;
  int          cycles = 0;

  cdf_in_if  in_ch ();
  cdf_out_if out_ch ();

  deframe_scoreboard sb;

  crc16_frame_deframer_unit #(
    .FRAME_STORE_DEPTH(STORE_DEPTH),
    .PAYLOAD_DEPTH    (PL_DEPTH)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_ch),
    .out_o   (out_ch)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Abort on a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Check every result transfer.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.result_kind, out_ch.frame_cmd, out_ch.body_len,
                      out_ch.read_data, out_ch.last_result);
  end

  // Receiver: random ready runs and gaps; a hold request forces one long stall.
  initial begin
    int run_len, gap;
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req && !held) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        held = 1'b1;
      end
      run_len = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8);
      out_ch.ready <= 1'b1;
      repeat (run_len) @(posedge clk_i);
      gap = $urandom_range(0, 19) == 0 ? $urandom_range(15, 50) : $urandom_range(0, 3);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // Send one transfer, after a random gap unless in a burst; hold valid across back-to-back items.
  task automatic send_item(input logic act, input logic [7:0] rx, input logic [7:0] idx,
                           input bit burst);
    int gap;
    gap = burst ? 0 :
          ($urandom_range(0, 24) == 0 ? $urandom_range(10, 40) : $urandom_range(0, 2));
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.rx_byte    <= rx;
    in_ch.read_index <= idx;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
    sb.note_input(act, rx, idx);
  endtask

  task automatic push_byte(input logic [7:0] b, input bit burst);
    send_item(1'b0, b, 8'($urandom), burst);
  endtask

  task automatic read_payload(input logic [7:0] idx);
    send_item(1'b1, 8'($urandom), idx, 1'b0);
  endtask

  // Build and push a frame; optionally flip one bit to break the CRC.
  task automatic push_frame(input logic [7:0] addr, input logic [7:0] cmd, input int len,
                            input bit corrupt, output int sent);
    logic [7:0]  fb[$];
    logic [15:0] crc;
    int          pos;
    bit          burst;
    fb = {HDR0, HDR1, addr, cmd, 8'(len)};
    for (int i = 0; i < len; i++) fb.push_back(8'($urandom));
    crc = 16'hFFFF;
    foreach (fb[i]) begin
      crc ^= {8'h00, fb[i]};
      for (int b = 0; b < 8; b++) crc = crc[0] ? ((crc >> 1) ^ 16'hA001) : (crc >> 1);
    end
    fb.push_back(crc[7:0]);
    fb.push_back(crc[15:8]);
    if (corrupt) begin
      pos = $urandom_range(5, fb.size() - 1);
      fb[pos] ^= 8'(1 << $urandom_range(0, 7));
    end
    burst = $urandom_range(0, 2) == 0;
    foreach (fb[i]) push_byte(fb[i], burst);
    sent = fb.size();
  endtask

  task automatic write_board_addr(input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * REG_BOARD_ADDR);
    pwdata  <= {24'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.board_addr = value;
  endtask

  // Pause the sender until every owed result has arrived, then let the block settle.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_items(input int count);
    int done, sent, r;
    done = 0;
    while (done < count) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        push_frame(sb.board_addr, 8'($urandom),
                   $urandom_range(0, 14) == 0 ? $urandom_range(9, 40) : $urandom_range(0, 8),
                   $urandom_range(0, 9) == 0, sent);
        done += sent;
      end else if (r < 63) begin
        push_frame(sb.board_addr ^ 8'($urandom_range(1, 255)), 8'($urandom),
                   $urandom_range(0, 6), 1'b0, sent);
        done += sent;
      end else if (r < 80) begin
        push_byte($urandom_range(0, 3) == 0 ? HDR0 : 8'($urandom), 1'b0);
        done++;
      end else begin
        read_payload($urandom_range(0, 1) ? 8'($urandom_range(0, 10))
                                          : 8'($urandom_range(0, 254)));
        done++;
      end
    end
  endtask

  initial begin
    int sent;
    sb = new();
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.action <= 1'b0;
    in_ch.rx_byte <= '0;
    in_ch.read_index <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reads before any frame, empty and short frames, bad CRC, wrong address.
    read_payload(8'd0);
    push_frame(8'd1, 8'h00, 0, 1'b0, sent);
    push_frame(8'd1, 8'hFF, 3, 1'b0, sent);
    read_payload(8'd0);
    read_payload(8'd2);
    read_payload(8'd3);
    read_payload(8'd254);
    push_frame(8'd1, 8'h5A, 1, 1'b1, sent);
    push_frame(8'd2, 8'h11, 1, 1'b0, sent);
    // Header, then a wrong address that is itself a header start.
    push_byte(HDR0, 1'b0);
    push_byte(HDR1, 1'b0);
    push_byte(HDR0, 1'b0);
    push_frame(8'd1, 8'h22, 2, 1'b0, sent);
    random_items(14);
    wait_drained();

    // Address equal to the first header byte: a long bad outer frame is followed by
    // overlapping broken candidates, so its completing byte hits the result cap.
    // Stall the receiver while the sender keeps offering these bytes.
    write_board_addr(HDR0);
    hold_req = 1'b1;
    push_byte(HDR0, 1'b1); push_byte(HDR1, 1'b1); push_byte(HDR0, 1'b1);
    push_byte(HDR1, 1'b1); push_byte(8'd162, 1'b1);
    for (int i = 0; i < 82; i++) begin
      push_byte(HDR0, 1'b1); push_byte(HDR1, 1'b1);
    end
    // Leftover scan work resumes on the next items.
    random_items(4);
    wait_drained();

    write_board_addr(8'h00);
    random_items(12);
    wait_drained();

    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/cdf_pkg.sv
hdl/cdf_in_if.sv
hdl/cdf_out_if.sv
hdl/cdf_ctrl.sv
hdl/cdf_datapath.sv
hdl/crc16_frame_deframer_unit.sv
tb/tb_crc16_frame_deframer_unit.sv
